// ===== hdl/hsc_pkg.sv =====
package hsc_pkg;

  // item kinds on the input channel and the report channel
  localparam logic KIND_ENCODER = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // setpoint handling
  localparam logic [8:0] SP_RESET      = 9'd200;
  localparam logic [8:0] SP_LOW_LIMIT  = 9'd50;
  localparam logic [8:0] SP_HIGH_LIMIT = 9'd390;
  localparam logic [8:0] SP_STEP       = 9'd5;
  localparam logic [8:0] SP_MIN        = 9'd45;
  localparam logic [8:0] SP_MAX        = 9'd395;

  // adc to temperature mapping: ((x * 285) / 430) + 25, x = heater + calib - 512
  localparam logic [11:0] ADC_OFFSET  = 12'd512;
  localparam logic [8:0]  MAP_GAIN    = 9'd285;
  localparam logic [8:0]  MAP_SPAN    = 9'd430;
  localparam logic [11:0] MAP_BASE    = 12'd25;
  // reciprocal of the span, scaled by 2^RECIP_SHIFT and rounded down
  localparam int unsigned RECIP_SHIFT = 25;
  localparam logic [16:0] RECIP       = 17'd78033;

  // duty levels
  localparam logic [7:0] DUTY_OFF  = 8'd0;
  localparam logic [7:0] DUTY_MID  = 8'd100;
  localparam logic [7:0] DUTY_LOW  = 8'd80;
  localparam logic [7:0] DUTY_TRIM = 8'd45;
  localparam logic [7:0] DUTY_FULL = 8'd230;

  typedef struct packed {
    logic       kind;
    logic       enc_clk;
    logic       enc_dt;
    logic [9:0] heater_adc;
    logic [9:0] calib_adc;
  } hsc_item_t;

  typedef struct packed {
    logic              report_kind;
    logic signed [11:0] temperature;
    logic [8:0]        setpoint;
    logic [7:0]        pwm_duty;
  } hsc_report_t;

  // work handed from the front to the back
  typedef struct packed {
    logic              report_kind;
    logic [8:0]        setpoint;
    logic signed [11:0] adc_sum;
  } hsc_cmd_t;

endpackage

// ===== hdl/hsc_stream_if.sv =====
interface hsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/hsc_front.sv =====
module hsc_front (
  input  logic              clk,
  input  logic              rst,
  hsc_stream_if.sink        item,
  output logic              push_valid,
  input  logic              push_ready,
  output hsc_pkg::hsc_cmd_t push_cmd
);

  logic       last_clk;
  logic [8:0] target_temp;
  logic [8:0] target_temp_next;
  logic       accept;
  logic       falling;

  assign item.ready = push_ready;
  assign accept     = item.valid && item.ready;
  assign falling    = (item.data.kind == hsc_pkg::KIND_ENCODER) &&
                      !item.data.enc_clk && last_clk;

  always_comb begin
    target_temp_next = target_temp;
    if (item.data.enc_dt) begin
      if (target_temp >= hsc_pkg::SP_LOW_LIMIT) target_temp_next = target_temp - hsc_pkg::SP_STEP;
    end else begin
      if (target_temp <= hsc_pkg::SP_HIGH_LIMIT) target_temp_next = target_temp + hsc_pkg::SP_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_clk    <= 1'b0;
      target_temp <= hsc_pkg::SP_RESET;
    end else if (accept && item.data.kind == hsc_pkg::KIND_ENCODER) begin
      last_clk <= item.data.enc_clk;
      if (falling) target_temp <= target_temp_next;
    end
  end

  always_comb begin
    push_valid           = item.valid && (item.data.kind == hsc_pkg::KIND_TICK || falling);
    push_cmd.report_kind = item.data.kind;
    if (item.data.kind == hsc_pkg::KIND_TICK) begin
      push_cmd.setpoint = target_temp;
      push_cmd.adc_sum  = $signed({2'b00, item.data.heater_adc} + {2'b00, item.data.calib_adc} -
                                  hsc_pkg::ADC_OFFSET);
    end else begin
      push_cmd.setpoint = target_temp_next;
      push_cmd.adc_sum  = 12'sd0;
    end
  end

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    target_temp >= hsc_pkg::SP_MIN && target_temp <= hsc_pkg::SP_MAX)
    else $error("setpoint left its range");

  a_sp_hold_on_tick: assert property (@(posedge clk) disable iff (rst)
    accept && item.data.kind == hsc_pkg::KIND_TICK |=> target_temp == $past(target_temp))
    else $error("setpoint moved on a tick");

endmodule

// ===== hdl/hsc_queue.sv =====
module hsc_queue #(
  parameter int Depth = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  hsc_pkg::hsc_cmd_t push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output hsc_pkg::hsc_cmd_t pop_cmd
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  hsc_pkg::hsc_cmd_t mem [Depth];
  logic [PtrW-1:0]   wptr;
  logic [PtrW-1:0]   rptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (do_pop) rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue fill beyond depth");

endmodule

// ===== hdl/hsc_back.sv =====
module hsc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  hsc_pkg::hsc_cmd_t pop_cmd,
  hsc_stream_if.source      report
);

  // stage 1: magnitude times gain
  logic        v1;
  logic        s1_kind;
  logic [8:0]  s1_sp;
  logic        s1_neg;
  logic [18:0] s1_p;
  // stage 2: estimate of the quotient
  logic        v2;
  logic        s2_kind;
  logic [8:0]  s2_sp;
  logic        s2_neg;
  logic [18:0] s2_p;
  logic [9:0]  s2_q0;
  // stage 3: corrected quotient and temperature
  logic        v3;
  logic        s3_kind;
  logic [8:0]  s3_sp;
  logic [11:0] s3_temp;
  // stage 4: output register
  logic                 v4;
  hsc_pkg::hsc_report_t s4;

  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4 || report.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign pop_ready = rdy1;

  logic [10:0] mag;
  logic [35:0] prod2;
  logic [19:0] rem3;
  logic [10:0] q3;
  logic        below4;
  logic [8:0]  d4;
  logic [7:0]  duty4;

  assign mag   = pop_cmd.adc_sum[11] ? 11'(-pop_cmd.adc_sum) : pop_cmd.adc_sum[10:0];
  assign prod2 = 36'(s1_p) * 36'(hsc_pkg::RECIP);
  assign rem3  = 20'(s2_p) - 20'(s2_q0) * 20'(hsc_pkg::MAP_SPAN);
  assign q3    = (rem3 >= 20'(hsc_pkg::MAP_SPAN)) ? 11'(s2_q0) + 11'd1 : 11'(s2_q0);

  always_comb begin
    below4 = !s3_temp[11] && (s3_temp[10:0] < 11'(s3_sp));
    d4     = s3_sp - s3_temp[8:0];
    duty4  = hsc_pkg::DUTY_OFF;
    if (s3_kind == hsc_pkg::KIND_TICK && below4) begin
      case (d4) inside
        [9'd7:9'd15]: duty4 = hsc_pkg::DUTY_MID;
        [9'd5:9'd6]:  duty4 = hsc_pkg::DUTY_LOW;
        [9'd1:9'd3]:  duty4 = hsc_pkg::DUTY_TRIM;
        default:      duty4 = hsc_pkg::DUTY_FULL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pop_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_kind <= pop_cmd.report_kind;
      s1_sp   <= pop_cmd.setpoint;
      s1_neg  <= pop_cmd.adc_sum[11];
      s1_p    <= 19'(mag) * 19'(hsc_pkg::MAP_GAIN);
    end
    if (rdy2) begin
      s2_kind <= s1_kind;
      s2_sp   <= s1_sp;
      s2_neg  <= s1_neg;
      s2_p    <= s1_p;
      s2_q0   <= prod2[hsc_pkg::RECIP_SHIFT +: 10];
    end
    if (rdy3) begin
      s3_kind <= s2_kind;
      s3_sp   <= s2_sp;
      s3_temp <= s2_neg ? hsc_pkg::MAP_BASE - 12'(q3) : hsc_pkg::MAP_BASE + 12'(q3);
    end
    if (rdy4) begin
      s4.report_kind <= s3_kind;
      s4.temperature <= (s3_kind == hsc_pkg::KIND_TICK) ? $signed(s3_temp) : 12'sd0;
      s4.setpoint    <= s3_sp;
      s4.pwm_duty    <= duty4;
    end
  end

  assign report.valid = v4;
  assign report.data  = s4;

  a_encoder_fields_zero: assert property (@(posedge clk) disable iff (rst)
    v4 && s4.report_kind == hsc_pkg::KIND_ENCODER |->
      s4.temperature == 12'sd0 && s4.pwm_duty == hsc_pkg::DUTY_OFF)
    else $error("encoder report carries temperature or duty");

  a_duty_only_below: assert property (@(posedge clk) disable iff (rst)
    v4 && s4.pwm_duty != hsc_pkg::DUTY_OFF |->
      s4.temperature >= 12'sd0 && s4.temperature < $signed({3'b000, s4.setpoint}))
    else $error("heater driven at or above setpoint");

endmodule

// ===== hdl/heater_setpoint_step_controller_core.sv =====
// channel  | role   | payload      | transaction
// ---------+--------+--------------+-----------------------------------------
// item     | sink   | hsc_item_t   | encoder line sample or control tick
// report   | source | hsc_report_t | setpoint report or control update
//
// one transaction accepted per cycle when the queue has room
// an accepted item passes the queue and the four-stage back end before its
// report is valid: gain product, quotient estimate, correction, output register
// the temperature divide is a reciprocal multiply and a one-step correction
// rst is synchronous: setpoint returns to 200, queue and pipeline empty
// a stalled report fills the pipeline, then the queue, then drops item.ready
module heater_setpoint_step_controller_core #(
  parameter int QueueDepth = 2
) (
  input  logic         clk,
  input  logic         rst,
  hsc_stream_if.sink   item,
  hsc_stream_if.source report
);

  // front to queue
  logic              push_valid;
  logic              push_ready;
  hsc_pkg::hsc_cmd_t push_cmd;
  // queue to back
  logic              pop_valid;
  logic              pop_ready;
  hsc_pkg::hsc_cmd_t pop_cmd;

  // front: edge detection on the encoder clock line and setpoint stepping;
  // ticks pick up the setpoint as it stands when they arrive
  hsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // short queue so the front keeps taking items while the back stalls
  hsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: temperature mapping, duty band and the output register
  hsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .report    (report)
  );

endmodule
